// ----- hw/rtl/tcc_pkg.sv -----
// Shared types, constants and helpers for the trajectory comfort cost block.
// Used by tcc_mul, tcc_div and trajectory_comfort_cost; no dependencies.
`default_nettype none
package tcc_pkg;

    localparam int unsigned CFG_W  = 48;
    localparam int unsigned NUM_W  = 48;
    localparam int unsigned DEN_W  = 32;

    localparam logic [31:0] TINY_Q16   = 32'd66;
    localparam logic [30:0] LIM31      = 31'h7FFF_FFFF;
    localparam logic [15:0] SMAX_FLOOR = 16'd256;

    localparam logic [31:0] RST_STEP_TIME  = 32'd6554;
    localparam logic [31:0] RST_STEP_RATE  = 32'd655360;
    localparam logic [31:0] RST_WEIGHT     = 32'd65536;
    localparam logic [2:0]  RST_POWER      = 3'd1;
    localparam logic [47:0] RST_TERM_W     = 48'd24408404006464;
    localparam logic [47:0] RST_TERM_DB    = 48'd70480818090008;
    localparam logic [31:0] RST_LIMITS     = 32'd25165888;
    localparam logic [31:0] RST_RADIUS     = 32'd0;

    typedef enum logic [2:0] {
        CFG_STEP_TIME  = 3'd0,
        CFG_STEP_RATE  = 3'd1,
        CFG_WEIGHT     = 3'd2,
        CFG_POWER      = 3'd3,
        CFG_TERM_W     = 3'd4,
        CFG_TERM_DB    = 3'd5,
        CFG_LIMITS     = 3'd6,
        CFG_RADIUS     = 3'd7
    } cfg_idx_t;

    // Request to the shared multiplier: start pulse and shift select (16 or 6).
    typedef struct packed {
        logic start;
        logic sh16;
    } mul_req_t;

    // Clamp a magnitude to 2^31-1 and apply the sign.
    function automatic logic signed [31:0] clamp31(input logic [63:0] m, input logic neg);
        logic [30:0] mm;
        mm = (m > {33'd0, LIM31}) ? LIM31 : m[30:0];
        return neg ? -$signed({1'b0, mm}) : $signed({1'b0, mm});
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tcc_mul.sv -----
// Shared saturating 64x64 multiplier: (a*b)>>sh clamped to 64 bits.
// Four 32x32 partial products over successive cycles; uses tcc_pkg.
`default_nettype none
module tcc_mul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tcc_pkg::mul_req_t req,
    input  wire logic [63:0]       op_a,
    input  wire logic [63:0]       op_b,
    output logic [63:0]            product,
    output logic                   done
);
    import tcc_pkg::*;

    logic [63:0]  a_reg, b_reg;
    logic         sh16_reg;
    logic [1:0]   idx_reg;
    logic [1:0]   ppos_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;
    logic         run_reg, acc_en_reg, fin_reg, done_reg;
    logic [63:0]  prod_reg;

    logic [31:0]  a_half, b_half;
    logic [127:0] shifted;

    assign a_half  = idx_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half  = idx_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign shifted = sh16_reg ? (acc_reg >> 16) : (acc_reg >> 6);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= 1'b0;
            acc_en_reg <= 1'b0;
            fin_reg    <= 1'b0;
            done_reg   <= 1'b0;
            idx_reg    <= 2'd0;
        end else begin
            done_reg <= !req.start && fin_reg;
            if (req.start) begin
                run_reg    <= 1'b1;
                acc_en_reg <= 1'b0;
                fin_reg    <= 1'b0;
                idx_reg    <= 2'd0;
            end else begin
                acc_en_reg <= run_reg;
                if (run_reg) begin
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        run_reg <= 1'b0;
                    end
                end
                fin_reg <= acc_en_reg && !run_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg    <= op_a;
            b_reg    <= op_b;
            sh16_reg <= req.sh16;
            acc_reg  <= '0;
        end else begin
            if (run_reg) begin
                pp_reg   <= a_half * b_half;
                ppos_reg <= {1'b0, idx_reg[1]} + {1'b0, idx_reg[0]};
            end
            if (acc_en_reg) begin
                acc_reg <= acc_reg + ({64'd0, pp_reg} << {ppos_reg, 5'd0});
            end
            if (fin_reg) begin
                prod_reg <= (|shifted[127:64]) ? '1 : shifted[63:0];
            end
        end
    end

    assign product = prod_reg;
    assign done    = done_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/tcc_div.sv -----
// Restoring divider, one quotient bit per cycle: 48-bit numerator by 32-bit divisor.
// Feeds the steering normalization; uses tcc_pkg widths.
`default_nettype none
module tcc_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [tcc_pkg::NUM_W-1:0] num,
    input  wire logic [tcc_pkg::DEN_W-1:0] den,
    output logic [tcc_pkg::NUM_W-1:0]      quo,
    output logic                           done
);
    import tcc_pkg::*;

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [5:0]       cnt_reg;
    logic             run_reg, done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && run_reg && (cnt_reg == 6'(NUM_W - 1));
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUM_W - 1)) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (run_reg) begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/trajectory_comfort_cost.sv -----
// Trajectory comfort cost: per-step comfort penalties over a rollout, cost on last step.
// Top level with the step sequencer; uses tcc_pkg, tcc_mul and tcc_div.
//
// Usage:
//  - s_ channel: one rollout time step per transfer. s_tdata[31:0] speed,
//    s_tdata[63:32] yaw rate (both signed Q16.16), s_tlast marks the final step.
//  - m_ channel: one cost transfer (unsigned Q48.16, saturating) per rollout,
//    issued after the step carrying s_tlast; other steps give no result.
//  - cfg_we/cfg_addr/cfg_wdata: register writes, taken on any edge with cfg_we
//    high. Write only while the block is idle.
//  - Throughput: one step at a time; s_tready is high only while idle.
//    Each step runs through one shared 64x64 multiplier (four 32x32 partial
//    products per multiply) and a restoring divider for the steering ratio.
//    A step takes longest with all six terms active; the last step also
//    runs the weight multiply, the result hand-off and one multiply per
//    extra power step.
//  - Result register: the cost waits in its own register, so the next step
//    is accepted while m_ is stalled; a second cost waits until the first
//    transfer completes.
//  - Reset (aresetn low, synchronous): registers take their reset values,
//    history and running sum clear, no result is pending.
`default_nettype none
module trajectory_comfort_cost (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input steps
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] speed, [63:32] yaw_rate
    input  wire logic        s_tlast,   // last step of the rollout
    // result
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] cost
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [tcc_pkg::CFG_W-1:0] cfg_wdata
);
    import tcc_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_LAT   = 12'b0000_0000_0010,
        ST_DISP  = 12'b0000_0000_0100,
        ST_DIFF  = 12'b0000_0000_1000,
        ST_PEN1  = 12'b0000_0001_0000,
        ST_PEN2  = 12'b0000_0010_0000,
        ST_PEN3  = 12'b0000_0100_0000,
        ST_DIV   = 12'b0000_1000_0000,
        ST_STEER = 12'b0001_0000_0000,
        ST_FIN   = 12'b0010_0000_0000,
        ST_POW   = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        JOB_LAT_JERK  = 3'd0,
        JOB_LONG_JERK = 3'd1,
        JOB_STEER     = 3'd2,
        JOB_EFFORT    = 3'd3,
        JOB_RATE      = 3'd4,
        JOB_ACCEL     = 3'd5,
        JOB_DONE      = 3'd6
    } job_t;

    // configuration registers
    logic [31:0] step_time_reg, step_rate_reg, weight_reg, limits_reg, radius_reg;
    logic [2:0]  power_reg;
    logic [47:0] term_w_reg, term_db_reg;

    // control
    state_t      state_reg;
    job_t        job_reg;
    logic        wait_reg;
    logic [1:0]  dcnt_reg;
    logic        ser_reg;
    logic [2:0]  tidx_reg;
    logic [2:0]  pcnt_reg;
    logic [1:0]  seen_reg;
    logic        out_valid_reg;

    // payload
    logic signed [31:0] v_reg, w_reg, a_reg, n_reg, x_reg, d1_reg;
    logic signed [31:0] ps0_reg, ps1_reg, pa_reg, pn0_reg, pn1_reg;
    logic               last_reg;
    logic signed [32:0] delta_reg;
    logic [63:0]        sum_reg, t_reg, base_reg, r_reg, out_reg;
    logic [47:0]        q_reg;

    // shared units
    mul_req_t    mreq;
    logic [63:0] m_a, m_b, m_p;
    logic        m_done;
    logic        div_start, div_done;
    logic [47:0] div_q;

    // combinational helpers
    logic [31:0] v_mag, w_mag, x_mag, delta_mag, db, e;
    logic [23:0] vmin, smax;
    logic [31:0] den, radius_eff;
    logic [7:0]  tw;
    logic        is_mul_state, steer_on;
    logic signed [31:0] dres;
    logic [64:0] sum_add;
    logic [23:0] qq;

    assign v_mag      = mag32(v_reg);
    assign w_mag      = mag32(w_reg);
    assign x_mag      = mag32(x_reg);
    assign delta_mag  = delta_reg[32] ? 32'(-delta_reg) : delta_reg[31:0];
    assign db         = {13'd0, term_db_reg[{tidx_reg, 3'b000} +: 8], 11'd0};
    assign tw         = term_w_reg[{tidx_reg, 3'b000} +: 8];
    assign e          = (x_mag > db) ? (x_mag - db) : 32'd0;
    assign vmin       = ({limits_reg[15:0], 8'd0} < 24'(TINY_Q16)) ? 24'(TINY_Q16)
                                                                 : {limits_reg[15:0], 8'd0};
    assign smax       = (limits_reg[31:16] < SMAX_FLOOR) ? {SMAX_FLOOR, 8'd0}
                                                         : {limits_reg[31:16], 8'd0};
    assign den        = (v_mag < {8'd0, vmin}) ? {8'd0, vmin} : v_mag;
    assign radius_eff = (radius_reg < TINY_Q16) ? TINY_Q16 : radius_reg;
    assign steer_on   = radius_reg != 32'd0;
    assign dres       = clamp31(m_p, delta_reg[32]);
    assign sum_add    = {1'b0, sum_reg} + {1'b0, m_p};
    assign qq         = (m_p > {40'd0, smax}) ? smax : m_p[23:0];

    assign is_mul_state = (state_reg == ST_LAT)  || (state_reg == ST_DIFF) ||
                          (state_reg == ST_PEN1) || (state_reg == ST_PEN2) ||
                          (state_reg == ST_PEN3) || (state_reg == ST_STEER) ||
                          (state_reg == ST_FIN)  || (state_reg == ST_POW);

    // operand select for the shared multiplier
    always_comb begin
        mreq.start = is_mul_state && !wait_reg;
        mreq.sh16  = 1'b1;
        m_a        = '0;
        m_b        = '0;
        unique case (state_reg)
            ST_LAT: begin
                m_a = {32'd0, v_mag};
                m_b = {32'd0, w_mag};
            end
            ST_DIFF: begin
                m_a = {32'd0, delta_mag};
                m_b = {32'd0, step_rate_reg};
            end
            ST_PEN1: begin
                m_a = {32'd0, e};
                m_b = {32'd0, e};
            end
            ST_PEN2: begin
                m_a = t_reg;
                m_b = {32'd0, step_time_reg};
            end
            ST_PEN3: begin
                m_a = t_reg;
                m_b = {56'd0, tw};
                mreq.sh16 = 1'b0;
            end
            ST_STEER: begin
                m_a = {16'd0, q_reg};
                m_b = {32'd0, radius_eff};
            end
            ST_FIN: begin
                m_a = sum_reg;
                m_b = {32'd0, weight_reg};
            end
            ST_POW: begin
                m_a = r_reg;
                m_b = base_reg;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_DISP) && (job_reg == JOB_STEER);

    tcc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .op_a    (m_a),
        .op_b    (m_b),
        .product (m_p),
        .done    (m_done)
    );

    tcc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({w_mag, 16'd0}),
        .den     (den),
        .quo     (div_q),
        .done    (div_done)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg <= RST_STEP_TIME;
            step_rate_reg <= RST_STEP_RATE;
            weight_reg    <= RST_WEIGHT;
            power_reg     <= RST_POWER;
            term_w_reg    <= RST_TERM_W;
            term_db_reg   <= RST_TERM_DB;
            limits_reg    <= RST_LIMITS;
            radius_reg    <= RST_RADIUS;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_STEP_TIME: step_time_reg <= cfg_wdata[31:0];
                CFG_STEP_RATE: step_rate_reg <= cfg_wdata[31:0];
                CFG_WEIGHT:    weight_reg    <= cfg_wdata[31:0];
                CFG_POWER:     power_reg     <= cfg_wdata[2:0];
                CFG_TERM_W:    term_w_reg    <= cfg_wdata[47:0];
                CFG_TERM_DB:   term_db_reg   <= cfg_wdata[47:0];
                CFG_LIMITS:    limits_reg    <= cfg_wdata[31:0];
                CFG_RADIUS:    radius_reg    <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // step sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_LAT_JERK;
            wait_reg      <= 1'b0;
            dcnt_reg      <= 2'd0;
            ser_reg       <= 1'b0;
            tidx_reg      <= 3'd0;
            pcnt_reg      <= 3'd0;
            seen_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            ps0_reg       <= '0;
            ps1_reg       <= '0;
            pa_reg        <= '0;
            pn0_reg       <= '0;
            pn1_reg       <= '0;
        end else begin
            // ST_OUT reloads the result register itself
            if (m_tvalid && m_tready && state_reg != ST_OUT) begin
                out_valid_reg <= 1'b0;
            end
            // a multiply is outstanding from its start until done
            if (mreq.start) begin
                wait_reg <= 1'b1;
            end else if (m_done) begin
                wait_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        v_reg     <= s_tdata[31:0];
                        w_reg     <= s_tdata[63:32];
                        last_reg  <= s_tlast;
                        state_reg <= ST_LAT;
                    end
                end
                ST_LAT: begin
                    if (m_done) begin
                        a_reg     <= clamp31(m_p, v_reg[31] != w_reg[31]);
                        x_reg     <= clamp31(m_p, v_reg[31] != w_reg[31]);
                        tidx_reg  <= 3'd1;
                        job_reg   <= JOB_LAT_JERK;
                        state_reg <= ST_PEN1;
                    end
                end
                ST_DISP: begin
                    unique case (job_reg)
                        JOB_LAT_JERK: begin
                            job_reg <= JOB_LONG_JERK;
                            if (seen_reg != 2'd0) begin
                                delta_reg <= 33'(a_reg) - 33'(pa_reg);
                                dcnt_reg  <= 2'd0;
                                tidx_reg  <= 3'd2;
                                state_reg <= ST_DIFF;
                            end
                        end
                        JOB_LONG_JERK: begin
                            job_reg <= JOB_STEER;
                            if (seen_reg == 2'd2) begin
                                delta_reg <= 33'(v_reg) - 33'(ps0_reg);
                                dcnt_reg  <= 2'd2;
                                ser_reg   <= 1'b0;
                                tidx_reg  <= 3'd0;
                                state_reg <= ST_DIFF;
                            end
                        end
                        JOB_STEER: begin
                            job_reg   <= JOB_EFFORT;
                            state_reg <= ST_DIV;
                        end
                        JOB_EFFORT: begin
                            job_reg <= JOB_RATE;
                            if (steer_on) begin
                                x_reg     <= n_reg;
                                tidx_reg  <= 3'd3;
                                state_reg <= ST_PEN1;
                            end
                        end
                        JOB_RATE: begin
                            job_reg <= JOB_ACCEL;
                            if (steer_on && seen_reg != 2'd0) begin
                                delta_reg <= 33'(n_reg) - 33'(pn0_reg);
                                dcnt_reg  <= 2'd0;
                                tidx_reg  <= 3'd4;
                                state_reg <= ST_DIFF;
                            end
                        end
                        JOB_ACCEL: begin
                            job_reg <= JOB_DONE;
                            if (steer_on && seen_reg == 2'd2) begin
                                delta_reg <= 33'(n_reg) - 33'(pn0_reg);
                                dcnt_reg  <= 2'd2;
                                ser_reg   <= 1'b1;
                                tidx_reg  <= 3'd5;
                                state_reg <= ST_DIFF;
                            end
                        end
                        JOB_DONE: begin
                            if (last_reg) begin
                                pcnt_reg  <= power_reg;
                                state_reg <= ST_FIN;
                            end else begin
                                // commit history, keep the running sum
                                ps1_reg   <= ps0_reg;
                                ps0_reg   <= v_reg;
                                pa_reg    <= a_reg;
                                pn1_reg   <= pn0_reg;
                                pn0_reg   <= n_reg;
                                if (seen_reg != 2'd2) begin
                                    seen_reg <= seen_reg + 2'd1;
                                end
                                state_reg <= ST_IDLE;
                            end
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_DIFF: begin
                    if (m_done) begin
                        unique case (dcnt_reg)
                            2'd2: begin
                                d1_reg    <= dres;
                                delta_reg <= ser_reg ? 33'(pn0_reg) - 33'(pn1_reg)
                                                     : 33'(ps0_reg) - 33'(ps1_reg);
                                dcnt_reg  <= 2'd1;
                            end
                            2'd1: begin
                                delta_reg <= 33'(d1_reg) - 33'(dres);
                                dcnt_reg  <= 2'd0;
                            end
                            default: begin
                                x_reg     <= dres;
                                state_reg <= ST_PEN1;
                            end
                        endcase
                    end
                end
                ST_PEN1: begin
                    if (m_done) begin
                        t_reg     <= m_p;
                        state_reg <= ST_PEN2;
                    end
                end
                ST_PEN2: begin
                    if (m_done) begin
                        t_reg     <= m_p;
                        state_reg <= ST_PEN3;
                    end
                end
                ST_PEN3: begin
                    if (m_done) begin
                        sum_reg   <= sum_add[64] ? '1 : sum_add[63:0];
                        state_reg <= ST_DISP;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        q_reg     <= div_q;
                        state_reg <= ST_STEER;
                    end
                end
                ST_STEER: begin
                    if (m_done) begin
                        n_reg     <= w_reg[31] ? -$signed({8'd0, qq}) : $signed({8'd0, qq});
                        state_reg <= ST_DISP;
                    end
                end
                ST_FIN: begin
                    if (m_done) begin
                        base_reg  <= m_p;
                        r_reg     <= m_p;
                        state_reg <= (pcnt_reg > 3'd1) ? ST_POW : ST_OUT;
                    end
                end
                ST_POW: begin
                    if (m_done) begin
                        r_reg    <= m_p;
                        pcnt_reg <= pcnt_reg - 3'd1;
                        if (pcnt_reg == 3'd2) begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    // hold until the result register is free, then clear the rollout
                    if (!out_valid_reg || m_tready) begin
                        out_reg       <= r_reg;
                        out_valid_reg <= 1'b1;
                        sum_reg       <= '0;
                        ps0_reg       <= '0;
                        ps1_reg       <= '0;
                        pa_reg        <= '0;
                        pn0_reg       <= '0;
                        pn1_reg       <= '0;
                        seen_reg      <= 2'd0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire
